// ===== hdl/rtk_pkg.sv =====
// ============================================================================
// rtk_pkg: shared types, constants and the syllable table
// Types passed between the romaji-to-katakana modules, the fixed code points
// and the syllable lookup functions, split by key length.
// ============================================================================
package rtk_pkg;

    // code points used by the rules
    localparam logic [15:0] SMALL_TSU = 16'h30C3;
    localparam logic [15:0] KANA_N    = 16'h30F3;
    localparam logic [15:0] PUNCT_LO  = 16'h3000;
    localparam logic [15:0] PUNCT_HI  = 16'h303F;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_N      = 16'h006E;

    // number of results one unit can cause
    localparam int unsigned MAX_ITEMS = 3;

    // three pending units, entry 0 is the head
    typedef logic [2:0][15:0] t_win;

    // one table hit: k2 is zero when the syllable gives a single kana
    typedef struct packed {
        logic        hit;
        logic [15:0] k1;
        logic [15:0] k2;
    } t_kana;

    // outcome of one rule application: used == 0 means no rule matched
    typedef struct packed {
        logic [1:0]  used;
        logic        two;
        logic [15:0] k1;
        logic [15:0] k2;
    } t_rule;

    // all results caused by one accepted unit
    typedef struct packed {
        logic [1:0]                 cnt;
        logic                       eot;
        logic [MAX_ITEMS-1:0][15:0] kana;
        logic [MAX_ITEMS-1:0]       fail;
    } t_bundle;

    function automatic t_kana kana_of(input logic [15:0] a, input logic [15:0] b);
        t_kana r;
        r.hit = 1'b1;
        r.k1  = a;
        r.k2  = b;
        return r;
    endfunction

    // three-letter syllables
    function automatic t_kana rom_key3(input logic [15:0] c0, input logic [15:0] c1,
                                       input logic [15:0] c2);
        t_kana r;
        r = '0;
        if (c0[15:8] == 8'h00 && c1[15:8] == 8'h00 && c2[15:8] == 8'h00) begin
            case ({c0[7:0], c1[7:0], c2[7:0]})
                "shi": r = kana_of(16'h30B7, 16'h0000);
                "chi": r = kana_of(16'h30C1, 16'h0000);
                "tsu": r = kana_of(16'h30C4, 16'h0000);
                "kya": r = kana_of(16'h30AD, 16'h30E3);
                "kyu": r = kana_of(16'h30AD, 16'h30E5);
                "kyo": r = kana_of(16'h30AD, 16'h30E7);
                "gya": r = kana_of(16'h30AE, 16'h30E3);
                "gyu": r = kana_of(16'h30AE, 16'h30E5);
                "gyo": r = kana_of(16'h30AE, 16'h30E7);
                "sha": r = kana_of(16'h30B7, 16'h30E3);
                "shu": r = kana_of(16'h30B7, 16'h30E5);
                "sho": r = kana_of(16'h30B7, 16'h30E7);
                "cha": r = kana_of(16'h30C1, 16'h30E3);
                "chu": r = kana_of(16'h30C1, 16'h30E5);
                "cho": r = kana_of(16'h30C1, 16'h30E7);
                "dja": r = kana_of(16'h30C2, 16'h30E3);
                "dju": r = kana_of(16'h30C2, 16'h30E5);
                "djo": r = kana_of(16'h30C2, 16'h30E7);
                "nya": r = kana_of(16'h30CB, 16'h30E3);
                "nyu": r = kana_of(16'h30CB, 16'h30E5);
                "nyo": r = kana_of(16'h30CB, 16'h30E7);
                "hya": r = kana_of(16'h30D2, 16'h30E3);
                "hyu": r = kana_of(16'h30D2, 16'h30E5);
                "hyo": r = kana_of(16'h30D2, 16'h30E7);
                "bya": r = kana_of(16'h30D3, 16'h30E3);
                "byu": r = kana_of(16'h30D3, 16'h30E5);
                "byo": r = kana_of(16'h30D3, 16'h30E7);
                "pya": r = kana_of(16'h30D4, 16'h30E3);
                "pyu": r = kana_of(16'h30D4, 16'h30E5);
                "pyo": r = kana_of(16'h30D4, 16'h30E7);
                "mya": r = kana_of(16'h30DF, 16'h30E3);
                "myu": r = kana_of(16'h30DF, 16'h30E5);
                "myo": r = kana_of(16'h30DF, 16'h30E7);
                "rya": r = kana_of(16'h30EA, 16'h30E3);
                "ryu": r = kana_of(16'h30EA, 16'h30E5);
                "ryo": r = kana_of(16'h30EA, 16'h30E7);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    // two-letter syllables
    function automatic t_kana rom_key2(input logic [15:0] c0, input logic [15:0] c1);
        t_kana r;
        r = '0;
        if (c0[15:8] == 8'h00 && c1[15:8] == 8'h00) begin
            case ({c0[7:0], c1[7:0]})
                "ka": r = kana_of(16'h30AB, 16'h0000);
                "ki": r = kana_of(16'h30AD, 16'h0000);
                "ku": r = kana_of(16'h30AF, 16'h0000);
                "ke": r = kana_of(16'h30B1, 16'h0000);
                "ko": r = kana_of(16'h30B3, 16'h0000);
                "ga": r = kana_of(16'h30AC, 16'h0000);
                "gi": r = kana_of(16'h30AE, 16'h0000);
                "gu": r = kana_of(16'h30B0, 16'h0000);
                "ge": r = kana_of(16'h30B2, 16'h0000);
                "go": r = kana_of(16'h30B4, 16'h0000);
                "sa": r = kana_of(16'h30B5, 16'h0000);
                "si": r = kana_of(16'h30B7, 16'h0000);
                "su": r = kana_of(16'h30B9, 16'h0000);
                "se": r = kana_of(16'h30BB, 16'h0000);
                "so": r = kana_of(16'h30BD, 16'h0000);
                "za": r = kana_of(16'h30B6, 16'h0000);
                "zi": r = kana_of(16'h30B8, 16'h0000);
                "ji": r = kana_of(16'h30B8, 16'h0000);
                "zu": r = kana_of(16'h30BA, 16'h0000);
                "ze": r = kana_of(16'h30BC, 16'h0000);
                "zo": r = kana_of(16'h30BE, 16'h0000);
                "ta": r = kana_of(16'h30BF, 16'h0000);
                "ti": r = kana_of(16'h30C1, 16'h0000);
                "tu": r = kana_of(16'h30C4, 16'h0000);
                "te": r = kana_of(16'h30C6, 16'h0000);
                "to": r = kana_of(16'h30C8, 16'h0000);
                "da": r = kana_of(16'h30C0, 16'h0000);
                "di": r = kana_of(16'h30C2, 16'h0000);
                "du": r = kana_of(16'h30C5, 16'h0000);
                "de": r = kana_of(16'h30C7, 16'h0000);
                "do": r = kana_of(16'h30C9, 16'h0000);
                "na": r = kana_of(16'h30CA, 16'h0000);
                "ni": r = kana_of(16'h30CB, 16'h0000);
                "nu": r = kana_of(16'h30CC, 16'h0000);
                "ne": r = kana_of(16'h30CD, 16'h0000);
                "no": r = kana_of(16'h30CE, 16'h0000);
                "ha": r = kana_of(16'h30CF, 16'h0000);
                "hi": r = kana_of(16'h30D2, 16'h0000);
                "hu": r = kana_of(16'h30D5, 16'h0000);
                "fu": r = kana_of(16'h30D5, 16'h0000);
                "he": r = kana_of(16'h30D8, 16'h0000);
                "ho": r = kana_of(16'h30DB, 16'h0000);
                "ba": r = kana_of(16'h30D0, 16'h0000);
                "bi": r = kana_of(16'h30D3, 16'h0000);
                "bu": r = kana_of(16'h30D6, 16'h0000);
                "be": r = kana_of(16'h30D9, 16'h0000);
                "bo": r = kana_of(16'h30DC, 16'h0000);
                "pa": r = kana_of(16'h30D1, 16'h0000);
                "pi": r = kana_of(16'h30D4, 16'h0000);
                "pu": r = kana_of(16'h30D7, 16'h0000);
                "pe": r = kana_of(16'h30DA, 16'h0000);
                "po": r = kana_of(16'h30DD, 16'h0000);
                "ma": r = kana_of(16'h30DE, 16'h0000);
                "mi": r = kana_of(16'h30DF, 16'h0000);
                "mu": r = kana_of(16'h30E0, 16'h0000);
                "me": r = kana_of(16'h30E1, 16'h0000);
                "mo": r = kana_of(16'h30E2, 16'h0000);
                "ya": r = kana_of(16'h30E4, 16'h0000);
                "yu": r = kana_of(16'h30E6, 16'h0000);
                "yo": r = kana_of(16'h30E8, 16'h0000);
                "ra": r = kana_of(16'h30E9, 16'h0000);
                "ri": r = kana_of(16'h30EA, 16'h0000);
                "ru": r = kana_of(16'h30EB, 16'h0000);
                "re": r = kana_of(16'h30EC, 16'h0000);
                "ro": r = kana_of(16'h30ED, 16'h0000);
                "wa": r = kana_of(16'h30EF, 16'h0000);
                "wi": r = kana_of(16'h30A6, 16'h30A3);
                "wu": r = kana_of(16'h30A6, 16'h0000);
                "we": r = kana_of(16'h30A6, 16'h30A7);
                "wo": r = kana_of(16'h30F2, 16'h0000);
                "ja": r = kana_of(16'h30B8, 16'h30E3);
                "ju": r = kana_of(16'h30B8, 16'h30E5);
                "jo": r = kana_of(16'h30B8, 16'h30E7);
                "la": r = kana_of(16'h30A1, 16'h0000);
                "li": r = kana_of(16'h30A3, 16'h0000);
                "lu": r = kana_of(16'h30A5, 16'h0000);
                "le": r = kana_of(16'h30A7, 16'h0000);
                "lo": r = kana_of(16'h30A9, 16'h0000);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    // single-letter syllables and the long-vowel mark
    function automatic t_kana rom_key1(input logic [15:0] c0);
        t_kana r;
        r = '0;
        if (c0[15:8] == 8'h00) begin
            case (c0[7:0])
                "a":     r = kana_of(16'h30A2, 16'h0000);
                "i":     r = kana_of(16'h30A4, 16'h0000);
                "u":     r = kana_of(16'h30A6, 16'h0000);
                "e":     r = kana_of(16'h30A8, 16'h0000);
                "o":     r = kana_of(16'h30AA, 16'h0000);
                "-":     r = kana_of(16'h30FC, 16'h0000);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== hdl/rtk_rule.sv =====
// ============================================================================
// rtk_rule: one rule application at the head of the window
// Tries doubling, the syllable table, n and pass-through in that order and
// reports the kana produced and the number of units consumed.
// ============================================================================
module rtk_rule import rtk_pkg::*; (
    input  t_win       i_win,
    input  logic [1:0] i_fill,
    output t_rule      o_rule
);

    logic  dbl;
    logic  no_dbl;
    t_kana hit3;
    t_kana hit2;
    t_kana hit1;

    // vowels, y and n never double into small tsu
    assign no_dbl = (i_win[0][15:8] == 8'h00) &&
                    (i_win[0][7:0] inside {"a", "i", "u", "e", "o", "y", "n"});
    assign dbl    = (i_fill > 2'd1) && (i_win[1] == i_win[0]) && !no_dbl;

    // table lookups, each valid only when enough units are pending
    always_comb begin
        hit3 = rom_key3(i_win[0], i_win[1], i_win[2]);
        hit2 = rom_key2(i_win[0], i_win[1]);
        hit1 = rom_key1(i_win[0]);
        if (i_fill != 2'd3) begin
            hit3.hit = 1'b0;
        end
        if (i_fill < 2'd2) begin
            hit2.hit = 1'b0;
        end
        if (i_fill == 2'd0) begin
            hit1.hit = 1'b0;
        end
    end

    // rule priority
    always_comb begin
        o_rule = '0;
        if (dbl) begin
            o_rule.used = 2'd1;
            o_rule.k1   = SMALL_TSU;
        end else if (hit3.hit) begin
            o_rule.used = 2'd3;
            o_rule.k1   = hit3.k1;
            o_rule.k2   = hit3.k2;
            o_rule.two  = (hit3.k2 != 16'h0000);
        end else if (hit2.hit) begin
            o_rule.used = 2'd2;
            o_rule.k1   = hit2.k1;
            o_rule.k2   = hit2.k2;
            o_rule.two  = (hit2.k2 != 16'h0000);
        end else if (hit1.hit) begin
            o_rule.used = 2'd1;
            o_rule.k1   = hit1.k1;
        end else if (i_fill != 2'd0 && i_win[0] == CH_N) begin
            o_rule.used = (i_fill > 2'd1 && i_win[1] == CH_N) ? 2'd2 : 2'd1;
            o_rule.k1   = KANA_N;
        end else if (i_fill != 2'd0 &&
                     (i_win[0] inside {[PUNCT_LO:PUNCT_HI]} || i_win[0] == CH_STAR)) begin
            o_rule.used = 2'd1;
            o_rule.k1   = i_win[0];
        end
    end

endmodule

// ===== hdl/rtk_obuf.sv =====
// ============================================================================
// rtk_obuf: result register and serializer
// Holds one unit's results and hands them out one beat per cycle while the
// sink is ready; a new set loads as the previous set's last beat is taken.
// ============================================================================
module rtk_obuf import rtk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_bundle     i_bundle,
    output logic        o_ready,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // kana_code [15:0]
    output logic        o_m_tlast,   // end_of_text
    output logic        o_m_tuser    // fail
);

    t_bundle    r_bun;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last_beat;
    logic       done;

    assign last_beat = (r_idx == r_bun.cnt - 2'd1);
    assign done      = r_valid && i_m_tready && last_beat;
    assign o_ready   = !r_valid || done;

    // beat selection
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_bun.kana[r_idx];
    assign o_m_tuser  = r_bun.fail[r_idx];
    assign o_m_tlast  = r_bun.eot && last_beat;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load && i_bundle.cnt != 2'd0) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_m_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_bundle.cnt != 2'd0) begin
            r_bun <= i_bundle;
        end
    end

    // a held set is never empty and the index stays inside it
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_bun.cnt != 2'd0 && r_idx < r_bun.cnt))
        else $error("result set empty or index past its end");

    // a taken beat that is not the last advances by one
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_m_tready && !last_beat) |=>
            (r_valid && r_idx == $past(r_idx) + 2'd1))
        else $error("serializer did not advance");

    // the last beat taken with nothing new loaded empties the register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !(i_load && i_bundle.cnt != 2'd0)) |=> !r_valid)
        else $error("result register not released after last beat");

endmodule

// ===== hdl/romaji_to_katakana.sv =====
// ============================================================================
// romaji_to_katakana: romaji to katakana transliterator
// Collects lower-case romaji code units in a three-unit lookahead window and
// emits katakana code units, with a fail beat when a string does not parse.
//
//   channel  dir  tdata            tlast        tuser
//   s_*      in   char_code[15:0]  last_char    -
//   m_*      out  kana_code[15:0]  end_of_text  fail
//
// A unit is taken every cycle while the result register can take its
// results; up to three rule passes run combinationally between window and
// result register. Results leave one beat per cycle while m_tready is high;
// the first result beat appears in the cycle after its unit is taken. Reset
// empties the window and the result register; while a result set is held,
// s_tready stays low until its last beat is taken, so m_tready low stalls
// the input side as well.
// ============================================================================
module romaji_to_katakana import rtk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // char_code [15:0]
    input  logic        s_tlast,    // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // kana_code [15:0]
    output logic        m_tlast,    // end_of_text
    output logic        m_tuser     // fail
);

    t_win       r_win;
    logic [1:0] r_fill;
    logic       r_disc;

    logic       accept;
    logic [1:0] f0;
    t_win       w_app;
    t_win       st_win  [4];
    logic [1:0] st_fill [4];
    logic       st_run  [3];
    logic       st_fail [3];
    t_rule      st_rule [3];
    logic       any_fail;
    t_bundle    bun;

    assign accept = s_tvalid && s_tready;

    // append the new unit to the window
    always_comb begin
        f0 = (r_fill > 2'd2) ? 2'd2 : r_fill;
        w_app = r_win;
        w_app[f0] = s_tdata;
    end

    assign st_win[0]  = w_app;
    assign st_fill[0] = f0 + 2'd1;
    assign st_run[0]  = (st_fill[0] == 2'd3) || s_tlast;

    // rule passes: one once the window is full, up to three when flushing
    for (genvar k = 0; k < 3; k++) begin : g_pass
        rtk_rule u_rule (
            .i_win  (st_win[k]),
            .i_fill (st_fill[k]),
            .o_rule (st_rule[k])
        );

        always_comb begin
            st_win[k+1]  = st_win[k];
            st_fill[k+1] = st_fill[k];
            st_fail[k]   = 1'b0;
            if (st_run[k]) begin
                case (st_rule[k].used)
                    2'd0: st_fail[k] = 1'b1;
                    2'd1: st_win[k+1] = {16'h0000, st_win[k][2], st_win[k][1]};
                    2'd2: st_win[k+1] = {16'h0000, 16'h0000, st_win[k][2]};
                    default: st_win[k+1] = '0;
                endcase
                st_fill[k+1] = st_fill[k] - st_rule[k].used;
            end
        end

        if (k < 2) begin : g_next
            assign st_run[k+1] = st_run[k] && s_tlast && (st_rule[k].used != 2'd0) &&
                                 (st_fill[k+1] != 2'd0);
        end
    end

    assign any_fail = st_fail[0] || st_fail[1] || st_fail[2];

    // gather the results of all passes into one set
    always_comb begin
        logic [1:0] pos;
        pos = 2'd0;
        bun = '0;
        bun.eot = s_tlast;
        if (r_disc) begin
            if (s_tlast) begin
                bun.fail[0] = 1'b1;
                pos = 2'd1;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (st_run[k] && pos != 2'd3) begin
                    if (st_fail[k]) begin
                        bun.fail[pos] = 1'b1;
                        pos = pos + 2'd1;
                    end else begin
                        bun.kana[pos] = st_rule[k].k1;
                        pos = pos + 2'd1;
                        if (st_rule[k].two && pos != 2'd3) begin
                            bun.kana[pos] = st_rule[k].k2;
                            pos = pos + 2'd1;
                        end
                    end
                end
            end
        end
        bun.cnt = pos;
    end

    // window and discard state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= 2'd0;
            r_disc <= 1'b0;
        end else if (accept) begin
            if (r_disc) begin
                if (s_tlast) begin
                    r_disc <= 1'b0;
                end
            end else if (any_fail) begin
                r_win  <= '0;
                r_fill <= 2'd0;
                r_disc <= !s_tlast;
            end else begin
                r_win  <= st_win[3];
                r_fill <= st_fill[3];
            end
        end
    end

    rtk_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bundle   (bun),
        .o_ready    (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    // a full window is always resolved in the cycle it fills
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("window left full");

    // discarding only happens with an empty window
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_fill == 2'd0))
        else $error("units pending while discarding");

    // the end of a string leaves a clean state
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_tlast) |=> (r_fill == 2'd0 && !r_disc))
        else $error("state not cleared at end of string");

endmodule
